@@ sv/scit_pkg.sv @@
// ----------------------------------------------------------------------------
// scit_pkg: shared types and helpers for the substitution cipher translator
// Holds the token that walks the key cell chain, the ASCII letter bounds
// and the case helpers used at the chain entry and inside every cell.
// ----------------------------------------------------------------------------
package scit_pkg;

    localparam int ALPHA_LEN = 26;
    localparam int IDX_W     = 5;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;  // 'a'
    localparam logic [BYTE_W-1:0] CHAR_LZ = 8'h7A;  // 'z'
    localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] CHAR_UZ = 8'h5A;  // 'Z'

    localparam logic ACT_KEY_WRITE = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;
    localparam logic DIR_ENCODE    = 1'b0;
    localparam logic DIR_DECODE    = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              write;   // key entry write
        logic              enc;     // encode lookup at cell idx
        logic              seek;    // decode search, first match wins
        logic [IDX_W-1:0]  idx;     // key index or alphabet index of text
        logic [BYTE_W-1:0] data;    // key letter for a write
        logic [BYTE_W-1:0] result;
        logic              sub;
    } t_token;

    function automatic logic is_lower(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_LA) && (c <= CHAR_LZ);
    endfunction

    function automatic logic is_upper(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_UA) && (c <= CHAR_UZ);
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return is_upper(c) ? (c - CHAR_UA + CHAR_LA) : c;
    endfunction

endpackage

@@ sv/scit_cell.sv @@
// ----------------------------------------------------------------------------
// scit_cell: one key table entry of the translator chain
// Stores one key letter, applies a passing write, encode lookup or decode
// match to the token, and registers the token for the next cell.
// ----------------------------------------------------------------------------
module scit_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [scit_pkg::IDX_W-1:0]    i_cell_idx,
    input  scit_pkg::t_token              i_tok,
    output scit_pkg::t_token              o_tok
);

    logic [scit_pkg::BYTE_W-1:0] r_key;
    scit_pkg::t_token            r_tok;
    scit_pkg::t_token            n_tok;
    logic                        hit_idx;

    assign hit_idx = (i_tok.idx == i_cell_idx);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && i_tok.enc && hit_idx) begin
            n_tok.result = r_key;
            n_tok.sub    = 1'b1;
        end
        // first match only: later cells see sub set and leave the beat alone
        if (i_tok.valid && i_tok.seek && !i_tok.sub &&
            (scit_pkg::to_lower(r_key) == i_tok.result)) begin
            n_tok.result = scit_pkg::CHAR_LA + {3'b000, i_cell_idx};
            n_tok.sub    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_tok.valid && i_tok.write && hit_idx) begin
            r_key <= i_tok.data;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ sv/substitution_cipher_translator_unit.sv @@
// ----------------------------------------------------------------------------
// substitution_cipher_translator_unit: monoalphabetic substitution translator
// A beat enters every cycle unless the chain holds, and walks a chain of 26 registered key cells.
// Path: an accepted beat passes the 26 cell registers, then the output register.
// Throughput: one beat per cycle; the whole chain holds while a result stalls.
// Reset: synchronous active low; clears direction and chain valids, key table
// contents stay undefined until written.
// ----------------------------------------------------------------------------
module substitution_cipher_translator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [scit_pkg::IDX_W-1:0]    i_key_index,
    input  logic [scit_pkg::BYTE_W-1:0]   i_key_letter,
    input  logic [scit_pkg::BYTE_W-1:0]   i_text_byte,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [scit_pkg::BYTE_W-1:0]   o_result_byte,
    output logic                          o_substituted,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data
);

    logic                        r_direction;
    logic                        r_out_valid;
    logic [scit_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_out_sub;
    logic                        adv;
    logic                        is_letter;
    logic                        is_xlat;
    logic                        is_dec;
    logic [scit_pkg::BYTE_W-1:0] lc_byte;
    logic [scit_pkg::BYTE_W-1:0] alpha_off;
    scit_pkg::t_token            w_tok [0:scit_pkg::ALPHA_LEN];

    // advance the chain unless a finished result is held
    assign adv         = !(r_out_valid && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= scit_pkg::DIR_ENCODE;
        end else if (i_cfg_valid) begin
            r_direction <= i_cfg_data;
        end
    end

    assign lc_byte   = scit_pkg::to_lower(i_text_byte);
    assign is_letter = scit_pkg::is_lower(i_text_byte) || scit_pkg::is_upper(i_text_byte);
    assign alpha_off = lc_byte - scit_pkg::CHAR_LA;
    assign is_xlat   = (i_action == scit_pkg::ACT_TRANSLATE);
    assign is_dec    = (r_direction == scit_pkg::DIR_DECODE);

    always_comb begin
        w_tok[0].valid  = i_valid;
        w_tok[0].write  = (i_action == scit_pkg::ACT_KEY_WRITE);
        w_tok[0].enc    = is_xlat && !is_dec && is_letter;
        w_tok[0].seek   = is_xlat && is_dec && scit_pkg::is_lower(lc_byte);
        w_tok[0].idx    = is_xlat ? alpha_off[scit_pkg::IDX_W-1:0] : i_key_index;
        w_tok[0].data   = i_key_letter;
        w_tok[0].result = is_dec ? lc_byte : i_text_byte;
        w_tok[0].sub    = 1'b0;
    end

    for (genvar g = 0; g < scit_pkg::ALPHA_LEN; g++) begin : g_cell
        scit_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_cell_idx (scit_pkg::IDX_W'(g)),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    // drop key writes at the chain end; only translations yield a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w_tok[scit_pkg::ALPHA_LEN].valid &&
                           !w_tok[scit_pkg::ALPHA_LEN].write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= w_tok[scit_pkg::ALPHA_LEN].result;
            r_out_sub  <= w_tok[scit_pkg::ALPHA_LEN].sub;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_byte = r_out_byte;
    assign o_substituted = r_out_sub;

endmodule

@@ sv/scit_checker.sv @@
// ----------------------------------------------------------------------------
// scit_checker: port level checks for the substitution cipher translator
// Watches the result hold under stall, the input stall cause and reset.
// ----------------------------------------------------------------------------
module scit_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [scit_pkg::BYTE_W-1:0]   o_result_byte,
    input logic                          o_substituted
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_byte) && $stable(o_substituted))
        else $error("result beat changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind substitution_cipher_translator_unit scit_checker u_scit_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_byte (o_result_byte),
    .o_substituted (o_substituted)
);
